FILE: hdl/rational_reduce_defines.svh
// Assertion macros shared by the fraction reduction RTL.
`ifndef RATIONAL_REDUCE_DEFINES_SVH
`define RATIONAL_REDUCE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RR_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rr_pkg.sv
// Package with shared constants and operation codes for the fraction reducer.
package rr_pkg;

    // Default width of the numerator and denominator.
    localparam int RR_VALUE_WIDTH = 32;

    // Result kind codes.
    localparam logic [1:0] KIND_FRACTION = 2'd0;
    localparam logic [1:0] KIND_INTEGER  = 2'd1;
    localparam logic [1:0] KIND_ZERO_DEN = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // Operand selection for the shared subtractor.
    typedef enum logic
    {
        OP_DIV_STEP,
        OP_COMPARE
    } sub_op_t;

endpackage

FILE: hdl/rr_sub.sv
// Shared subtract and compare unit used by both the divider and the gcd loop.
module rr_sub #(
    parameter int WIDTH = rr_pkg::RR_VALUE_WIDTH
) (
    input  rr_pkg::sub_op_t   op,
    input  logic [WIDTH-1:0]  rem,
    input  logic              dvd_msb,
    input  logic [WIDTH-1:0]  dvs,
    input  logic [WIDTH-1:0]  u,
    input  logic [WIDTH-1:0]  v,
    output logic [WIDTH:0]    diff,
    output logic              ge
);
    import rr_pkg::*;

    logic [WIDTH:0]   opa;
    logic [WIDTH:0]   opb;
    logic [WIDTH+1:0] full;

    // Form the operands: a restoring division step or a plain compare of u and v.
    always_comb
    begin
        case (op)
            OP_DIV_STEP:
            begin
                opa = {rem, dvd_msb};
                opb = {1'b0, dvs};
            end
            OP_COMPARE:
            begin
                opa = {1'b0, u};
                opb = {1'b0, v};
            end
            default:
            begin
                opa = {1'b0, u};
                opb = {1'b0, v};
            end
        endcase
    end

    // One subtraction; the borrow out gives the comparison.
    assign full = {1'b0, opa} - {1'b0, opb};
    assign diff = full[WIDTH:0];
    assign ge   = ~full[WIDTH+1];

endmodule

FILE: hdl/rational_reduce.sv
// Top level of the fraction reducer: sequencer, working registers and result beat.
//
//  channel   signals                                        handshake
//  command   start, numerator_in, denominator_in             start && !busy
//  result    done, result_kind, numerator_out, denominator_out  done, one cycle
//
// A zero denominator answers in the cycle after the command beat.
// An exact quotient or an unreduced pair with negative denominator takes one
// restoring division.
// A full reduction adds a binary gcd (one subtract, shift or swap per cycle) and
// two more divisions; all of it runs on the one shared subtractor. Reset clears
// the sequencer and the result strobe at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "rational_reduce_defines.svh"

module rational_reduce #(
    parameter int VALUE_WIDTH = rr_pkg::RR_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] numerator_in,
    input  logic signed [VALUE_WIDTH-1:0] denominator_in,
    output logic                          done,
    output logic [1:0]                    result_kind,
    output logic signed [VALUE_WIDTH-1:0] numerator_out,
    output logic signed [VALUE_WIDTH-1:0] denominator_out
);
    import rr_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIV_ND,
        ST_GCD,
        ST_DIV_NG,
        ST_DIV_DG
    } state_t;

    state_t           state_reg, state_next;
    logic [W-1:0]     num_raw_reg, num_raw_next;
    logic [W-1:0]     den_raw_reg, den_raw_next;
    logic [W-1:0]     nmag_reg, nmag_next;
    logic [W-1:0]     dmag_reg, dmag_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     u_reg, u_next;
    logic [W-1:0]     v_reg, v_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [W-1:0]     nq_reg, nq_next;
    logic             done_reg, done_next;
    logic [1:0]       kind_reg, kind_next;
    logic [W-1:0]     num_out_reg, num_out_next;
    logic [W-1:0]     den_out_reg, den_out_next;

    sub_op_t          sub_op;
    logic [W:0]       sub_diff;
    logic             sub_ge;

    logic [W-1:0]     nraw;
    logic [W-1:0]     draw;
    logic [W-1:0]     in_nmag;
    logic [W-1:0]     in_dmag;
    logic             nneg;
    logic             dneg;
    logic [W-1:0]     quo_step;
    logic [W-1:0]     rem_step;
    logic             div_last;
    logic             qneg;

    // Shared subtractor: division steps everywhere except in the gcd loop.
    assign sub_op = (state_reg == ST_GCD) ? OP_COMPARE : OP_DIV_STEP;

    rr_sub #(
        .WIDTH (W)
    ) u_sub (
        .op      (sub_op),
        .rem     (rem_reg),
        .dvd_msb (dvd_reg[W-1]),
        .dvs     (dvs_reg),
        .u       (u_reg),
        .v       (v_reg),
        .diff    (sub_diff),
        .ge      (sub_ge)
    );

    // Magnitudes of the incoming terms; the most negative value maps onto itself.
    assign nraw    = numerator_in;
    assign draw    = denominator_in;
    assign in_nmag = nraw[W-1] ? (~nraw + 1'b1) : nraw;
    assign in_dmag = draw[W-1] ? (~draw + 1'b1) : draw;
    assign nneg    = num_raw_reg[W-1];
    assign dneg    = den_raw_reg[W-1];

    // Outcome of the current restoring division step.
    assign quo_step = {dvd_reg[W-2:0], sub_ge};
    assign rem_step = sub_ge ? sub_diff[W-1:0] : {rem_reg[W-2:0], dvd_reg[W-1]};
    assign div_last = (cnt_reg == CNT_W'(W - 1));
    assign qneg     = (nneg ^ dneg) && (quo_step != '0);

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next   = state_reg;
        num_raw_next = num_raw_reg;
        den_raw_next = den_raw_reg;
        nmag_next    = nmag_reg;
        dmag_next    = dmag_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        nq_next      = nq_reg;
        done_next    = 1'b0;
        kind_next    = kind_reg;
        num_out_next = num_out_reg;
        den_out_next = den_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_raw_next = nraw;
                    den_raw_next = draw;
                    nmag_next    = in_nmag;
                    dmag_next    = in_dmag;
                    if (draw == '0)
                    begin
                        // Zero denominator is answered straight away.
                        done_next    = 1'b1;
                        kind_next    = KIND_ZERO_DEN;
                        num_out_next = '0;
                        den_out_next = '0;
                    end
                    else
                    begin
                        dvd_next   = in_nmag;
                        dvs_next   = in_dmag;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV_ND;
                    end
                end
            end

            ST_DIV_ND:
            begin
                dvd_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    if (rem_step == '0)
                    begin
                        // Exact quotient, unless it does not fit.
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                        if (!qneg && quo_step[W-1])
                        begin
                            kind_next    = KIND_OVERFLOW;
                            num_out_next = '0;
                            den_out_next = '0;
                        end
                        else
                        begin
                            kind_next    = KIND_INTEGER;
                            num_out_next = qneg ? (~quo_step + 1'b1) : quo_step;
                            den_out_next = W'(1);
                        end
                    end
                    else if (dneg)
                    begin
                        // Negative denominator: the pair passes unchanged.
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                        kind_next    = KIND_FRACTION;
                        num_out_next = num_raw_reg;
                        den_out_next = den_raw_reg;
                    end
                    else
                    begin
                        u_next     = nmag_reg;
                        v_next     = dmag_reg;
                        k_next     = '0;
                        state_next = ST_GCD;
                    end
                end
            end

            ST_GCD:
            begin
                // Binary gcd: one shift, subtraction or swap per cycle.
                if (u_reg == '0)
                begin
                    dvd_next   = nmag_reg;
                    dvs_next   = v_reg << k_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV_NG;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (sub_ge)
                begin
                    u_next = sub_diff[W-1:0];
                end
                else
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end

            ST_DIV_NG:
            begin
                dvd_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    nq_next    = quo_step;
                    dvd_next   = dmag_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV_DG;
                end
            end

            ST_DIV_DG:
            begin
                dvd_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                    kind_next    = KIND_FRACTION;
                    num_out_next = nneg ? (~nq_reg + 1'b1) : nq_reg;
                    den_out_next = quo_step;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, working registers and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            num_raw_reg <= '0;
            den_raw_reg <= '0;
            nmag_reg    <= '0;
            dmag_reg    <= '0;
            dvd_reg     <= '0;
            dvs_reg     <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            u_reg       <= '0;
            v_reg       <= '0;
            k_reg       <= '0;
            nq_reg      <= '0;
            done_reg    <= 1'b0;
            kind_reg    <= KIND_FRACTION;
            num_out_reg <= '0;
            den_out_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            num_raw_reg <= num_raw_next;
            den_raw_reg <= den_raw_next;
            nmag_reg    <= nmag_next;
            dmag_reg    <= dmag_next;
            dvd_reg     <= dvd_next;
            dvs_reg     <= dvs_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            u_reg       <= u_next;
            v_reg       <= v_next;
            k_reg       <= k_next;
            nq_reg      <= nq_next;
            done_reg    <= done_next;
            kind_reg    <= kind_next;
            num_out_reg <= num_out_next;
            den_out_reg <= den_out_next;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign result_kind     = kind_reg;
    assign numerator_out   = $signed(num_out_reg);
    assign denominator_out = $signed(den_out_reg);

    // A result beat never overlaps work on a command.
    `RR_CHECK_NOW(a_done_not_busy, done, !busy, "result beat while busy")
    // A command with nonzero denominator starts the sequencer.
    `RR_CHECK_NEXT(a_start_busy, start && !busy && (denominator_in != '0), busy,
        "accepted command did not start work")
    // An integer answer carries denominator one.
    `RR_CHECK_NOW(a_int_den, done && (result_kind == KIND_INTEGER),
        denominator_out == W'(1), "integer result with denominator other than one")
    // Error answers carry zero terms.
    `RR_CHECK_NOW(a_err_zero,
        done && ((result_kind == KIND_ZERO_DEN) || (result_kind == KIND_OVERFLOW)),
        (numerator_out == '0) && (denominator_out == '0), "error result with nonzero terms")
    // The gcd loop never lets its second operand reach zero.
    `RR_CHECK_NOW(a_gcd_v_nonzero, state_reg == ST_GCD, v_reg != '0,
        "gcd operand reached zero")

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the fraction reducer: directed and random beats checked against a built-in predictor.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rr_pkg::*;

    localparam int VW = RR_VALUE_WIDTH;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 400;
    localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};

    // One expected answer: kind code and the two output terms.
    typedef struct packed
    {
        logic [1:0]           kind;
        logic signed [VW-1:0] num;
        logic signed [VW-1:0] den;
    } fraction_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start;
    logic                 busy;
    logic signed [VW-1:0] numerator_in;
    logic signed [VW-1:0] denominator_in;
    logic                 done;
    logic [1:0]           result_kind;
    logic signed [VW-1:0] numerator_out;
    logic signed [VW-1:0] denominator_out;

    fraction_t pending_fractions[$];
    int        mismatch_count = 0;
    int        idle_pct = 0;
    int        cycle_count = 0;

    rational_reduce #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .numerator_in    (numerator_in),
        .denominator_in  (denominator_in),
        .done            (done),
        .result_kind     (result_kind),
        .numerator_out   (numerator_out),
        .denominator_out (denominator_out)
    );

    // Free-running clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the normalised form of n/d exactly as the block should.
    function automatic fraction_t reduce_fraction(logic signed [VW-1:0] n,
                                                  logic signed [VW-1:0] d);
        logic [63:0] nmag;
        logic [63:0] dmag;
        logic [63:0] quot;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        bit          nneg;
        bit          dneg;
        bit          qneg;
        fraction_t   res;
        nneg = n[VW-1];
        dneg = d[VW-1];
        // Sign extension into 64 bits keeps the most negative value exact.
        nmag = nneg ? 64'(-longint'(n)) : 64'(n);
        dmag = dneg ? 64'(-longint'(d)) : 64'(d);
        if (dmag == 64'd0)
        begin
            res = '{KIND_ZERO_DEN, '0, '0};
        end
        else if (nmag % dmag == 64'd0)
        begin
            quot = nmag / dmag;
            qneg = (nneg != dneg) && (quot != 64'd0);
            if (!qneg && quot >= (64'd1 << (VW - 1)))
                res = '{KIND_OVERFLOW, '0, '0};
            else
                res = '{KIND_INTEGER, VW'(qneg ? 64'd0 - quot : quot), VW'(1)};
        end
        else if (dneg)
        begin
            // A negative denominator that does not divide is left alone.
            res = '{KIND_FRACTION, n, d};
        end
        else
        begin
            a = nmag;
            b = dmag;
            while (b != 64'd0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            quot = nmag / a;
            res = '{KIND_FRACTION, VW'(nneg ? 64'd0 - quot : quot), VW'(dmag / a)};
        end
        return res;
    endfunction

    // Present one command beat, record its expected answer, then maybe idle.
    task automatic send_fraction(input logic signed [VW-1:0] n,
                                 input logic signed [VW-1:0] d);
        start          <= 1'b1;
        numerator_in   <= n;
        denominator_in <= d;
        do @(posedge clk); while (busy);
        pending_fractions.push_back(reduce_fraction(n, d));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Hold off new commands until every outstanding answer has arrived.
    task automatic drain_fractions();
        start <= 1'b0;
        do @(posedge clk); while (pending_fractions.size() != 0);
    endtask

    // Zero denominators, the overflowing quotient and zero numerators.
    task automatic test_special_cases();
        send_fraction(5, 0);
        send_fraction(MOST_NEG, 0);
        send_fraction(0, 0);
        send_fraction(MOST_NEG, -1);
        send_fraction(0, 7);
        send_fraction(0, MOST_NEG);
    endtask

    // Exact quotients at the extremes and with mixed signs.
    task automatic test_exact_quotients();
        send_fraction(MOST_POS, 1);
        send_fraction(MOST_NEG, 1);
        send_fraction(MOST_NEG, MOST_NEG);
        send_fraction(MOST_POS, -1);
        send_fraction(-6, 3);
        send_fraction(6, -3);
        send_fraction(MOST_POS, MOST_POS);
        send_fraction(MOST_NEG, 2);
    endtask

    // Fractions needing reduction, and pass-through with a negative denominator.
    task automatic test_fractions();
        send_fraction(6, 4);
        send_fraction(-6, 4);
        send_fraction(MOST_NEG, MOST_POS);
        send_fraction(MOST_NEG, 6);
        send_fraction(1, MOST_POS);
        send_fraction(7, -2);
        send_fraction(MOST_NEG, -3);
        send_fraction(MOST_POS, MOST_NEG);
        send_fraction(-9, -6);
    endtask

    // Random beats, weighted towards pairs that share factors or divide exactly.
    task automatic test_random(input int count, input int pct);
        logic signed [VW-1:0] n;
        logic signed [VW-1:0] d;
        int unsigned          g;
        int unsigned          a;
        int unsigned          b;
        idle_pct = pct;
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    n = $urandom;
                    d = $urandom;
                end
                2, 3, 4:
                begin
                    g = 1 + ($urandom & ((32'd1 << $urandom_range(1, 16)) - 1));
                    a = $urandom_range(32767);
                    b = $urandom_range(1, 32767);
                    n = a * g;
                    d = b * g;
                    if ($urandom_range(1) == 1)
                        n = -n;
                    if ($urandom_range(3) == 0)
                        d = -d;
                end
                5, 6:
                begin
                    g = 1 + ($urandom_range(65534) >> $urandom_range(15));
                    a = $urandom_range(32767);
                    n = a * g;
                    d = g;
                    if ($urandom_range(1) == 1)
                        n = -n;
                    if ($urandom_range(1) == 1)
                        d = -d;
                end
                7:
                begin
                    n = $urandom;
                    d = $urandom_range(1, 64);
                    if ($urandom_range(1) == 1)
                        d = -d;
                end
                8:
                begin
                    case ($urandom_range(3))
                        0: begin n = $urandom; d = 0; end
                        1: begin n = MOST_NEG; d = -1; end
                        2: begin n = 0; d = $urandom; end
                        default:
                        begin
                            n = MOST_NEG;
                            d = VW'(1) << $urandom_range(VW - 2);
                            if ($urandom_range(1) == 1)
                                d = -d;
                        end
                    endcase
                end
                default:
                begin
                    // Powers of two times small odd factors stress the shift steps.
                    n = (VW'(1) << $urandom_range(VW - 2)) * (2 * $urandom_range(3) + 1);
                    d = (VW'(1) << $urandom_range(VW - 2)) * (2 * $urandom_range(3) + 1);
                    if ($urandom_range(1) == 1)
                        n = -n;
                end
            endcase
            send_fraction(n, d);
        end
    endtask

    // Compare each result beat with the oldest expected answer.
    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && done)
        begin
            if (pending_fractions.size() == 0)
            begin
                $error("unexpected result beat: kind %0d num %0d den %0d",
                       result_kind, numerator_out, denominator_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                    mismatch_count++;
                end
                if (numerator_out !== want.num)
                begin
                    $error("numerator_out: expected %0d, got %0d", want.num, numerator_out);
                    mismatch_count++;
                end
                if (denominator_out !== want.den)
                begin
                    $error("denominator_out: expected %0d, got %0d",
                           want.den, denominator_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rational_reduce regression: fail");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        start          <= 1'b0;
        numerator_in   <= '0;
        denominator_in <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_exact_quotients();
        test_fractions();
        drain_fractions();

        test_random(330, 10);
        drain_fractions();
        test_random(330, 73);
        test_random(340, 0);

        drain_fractions();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_fractions.size() == 0)
            $display("rational_reduce regression: pass");
        else
            $display("rational_reduce regression: fail");
        $finish;
    end

endmodule
